// ===== rtl/core/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared constants and types of the diamond scanline span filler.
// ----------------------------------------------------------------------------
package dsf_pkg;

   // grid limits
   localparam int GRID_ROWS_MAX = 32;
   localparam int GRID_COLS_MAX = 40;

   // field widths
   localparam int ROW_W   = 5;
   localparam int COL_W   = 6;
   localparam int CSR_W   = 6;
   localparam int HALF_W  = 7;
   localparam int PROD_W  = 2 * HALF_W;
   localparam int COORD_W = 10;

   // row command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // configuration register indexes
   localparam logic [0:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [0:0] CSR_GRID_COLS = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one row of work for the back end
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [HALF_W-1:0] row_gap;
      logic signed [7:0] center_x;
      logic [HALF_W-1:0] half_v;
      logic [HALF_W-1:0] half_h;
      logic              last;
   } cmd_type;

endpackage

// ===== rtl/core/diamond_scanline_span_fill.sv =====
// ----------------------------------------------------------------------------
// diamond_scanline_span_fill
// Scanline span generator for a diamond on a character grid.
// ----------------------------------------------------------------------------
// Each request beat carries one diamond; the block returns one span beat per
// visible grid row, top pass then bottom pass with the centre row twice, and
// marks the final span with tlast. A diamond with no visible row returns
// nothing. The front end takes a diamond while idle and queues one row command
// per cycle while the queue has room; it accepts the next diamond as soon as the
// previous one's rows are all queued. The back end works one row at a time
// (queue pop, multiply, the two-bit-per-cycle divider, clip), which sets the
// throughput; a diamond has up to 33 rows.
// Configuration writes take effect on the next clock and should be made idle.
// ----------------------------------------------------------------------------
module diamond_scanline_span_fill import dsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // config port
   input  logic             csr_wr_en,
   input  logic [0:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   // [7:0] center_x, [15:8] center_y, [23:16] shape_width, [31:24] shape_height
   input  logic [31:0]      req_tdata,
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [4:0] row, [10:5] first_column, [16:11] final_column, [23:17] zero
   output logic [23:0]      rsp_tdata,
   // [0] has_pixels
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic [CSR_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [CSR_W-1:0] rows_lim, cols_lim;

   cmd_type          f_cmd, q_cmd;
   logic             f_push, q_full, q_valid, q_pop;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_first, out_final;
   logic             out_has, out_last;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CSR_W'(GRID_ROWS_MAX);
         grid_cols_ff <= CSR_W'(GRID_COLS_MAX);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // saturate grid size
   assign rows_lim = (grid_rows_ff > CSR_W'(GRID_ROWS_MAX)) ? CSR_W'(GRID_ROWS_MAX)
                                                            : grid_rows_ff;
   assign cols_lim = (grid_cols_ff > CSR_W'(GRID_COLS_MAX)) ? CSR_W'(GRID_COLS_MAX)
                                                            : grid_cols_ff;

   dsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rows_lim   (rows_lim),
      .cmd_push   (f_push),
      .cmd        (f_cmd),
      .q_full     (q_full)
   );

   dsf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   (f_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_cmd),
      .valid (q_valid)
   );

   dsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .cols_lim   (cols_lim),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_row    (out_row),
      .out_first  (out_first),
      .out_final  (out_final),
      .out_has    (out_has),
      .out_last   (out_last)
   );

   // pack the response beat
   assign rsp_tdata = {7'b0, out_final, out_first, out_row};
   assign rsp_tuser = out_has;
   assign rsp_tlast = out_last;

endmodule

// ===== rtl/core/dsf_front.sv =====
// ----------------------------------------------------------------------------
// dsf_front
// Accepts a diamond, clips both scan passes to the visible rows and issues
// one row command per cycle into the queue while the queue has room.
// ----------------------------------------------------------------------------
module dsf_front import dsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic [CSR_W-1:0] rows_lim,
   output logic             cmd_push,
   output cmd_type          cmd,
   input  logic             q_full
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_UP   = 2'd1;
   localparam logic [1:0] F_DOWN = 2'd2;

   localparam coord_type ZERO = '0;
   localparam coord_type ONE  = coord_type'(1);

   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  py_ff, py_in;
   logic [ROW_W-1:0]  up_hi_ff, up_hi_in;
   logic [ROW_W-1:0]  dn_lo_ff, dn_lo_in;
   logic [ROW_W-1:0]  dn_hi_ff, dn_hi_in;
   logic              dn_ne_ff, dn_ne_in;
   coord_type         top_ff, top_in;
   coord_type         bot_ff, bot_in;
   logic signed [7:0] cx_ff, cx_in;
   logic [HALF_W-1:0] a_ff, a_in;
   logic [HALF_W-1:0] b_ff, b_in;

   coord_type cy, a_ext, rmax;
   coord_type up_lo, up_hi, dn_lo, dn_hi;
   coord_type py_ext, gap_full;
   logic      up_ne, dn_ne, accept, at_end;

   // decode the beat and clip both passes to [0, rows_lim)
   always_comb begin
      cy     = {{(COORD_W-8){req_tdata[15]}}, req_tdata[15:8]};
      a_ext  = {{(COORD_W-HALF_W){1'b0}}, req_tdata[23:17]};
      rmax   = coord_type'({{(COORD_W-CSR_W){1'b0}}, rows_lim}) - ONE;
      top_in = cy - a_ext;
      bot_in = cy + a_ext;
      up_lo  = (top_in < ZERO) ? ZERO : top_in;
      up_hi  = (cy < rmax) ? cy : rmax;
      dn_lo  = (cy < ZERO) ? ZERO : cy;
      dn_hi  = (bot_in < rmax) ? bot_in : rmax;
      up_ne  = (up_lo <= up_hi);
      dn_ne  = (dn_lo <= dn_hi);
      cx_in  = req_tdata[7:0];
      a_in   = req_tdata[23:17];
      b_in   = req_tdata[31:25];
   end

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cmd_push   = (state_ff != F_IDLE) && !q_full;

   // distance from the nearer vertex row
   always_comb begin
      py_ext   = {{(COORD_W-ROW_W){1'b0}}, py_ff};
      gap_full = (state_ff == F_UP) ? (py_ext - top_ff) : (bot_ff - py_ext);
      at_end   = (state_ff == F_UP) ? (py_ff == up_hi_ff) : (py_ff == dn_hi_ff);
   end

   always_comb begin
      cmd.row      = py_ff;
      cmd.row_gap  = gap_full[HALF_W-1:0];
      cmd.center_x = cx_ff;
      cmd.half_v   = a_ff;
      cmd.half_h   = b_ff;
      cmd.last     = at_end && ((state_ff == F_DOWN) || !dn_ne_ff);
   end

   // advance through the up pass, then the down pass
   always_comb begin
      state_in = state_ff;
      py_in    = py_ff;
      up_hi_in = up_hi_ff;
      dn_lo_in = dn_lo_ff;
      dn_hi_in = dn_hi_ff;
      dn_ne_in = dn_ne_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               up_hi_in = up_hi[ROW_W-1:0];
               dn_lo_in = dn_lo[ROW_W-1:0];
               dn_hi_in = dn_hi[ROW_W-1:0];
               dn_ne_in = dn_ne;
               if (up_ne) begin
                  state_in = F_UP;
                  py_in    = up_lo[ROW_W-1:0];
               end else if (dn_ne) begin
                  state_in = F_DOWN;
                  py_in    = dn_lo[ROW_W-1:0];
               end
            end
         end
         F_UP: begin
            if (cmd_push) begin
               if (at_end) begin
                  state_in = dn_ne_ff ? F_DOWN : F_IDLE;
                  py_in    = dn_lo_ff;
               end else begin
                  py_in = py_ff + ROW_W'(1);
               end
            end
         end
         F_DOWN: begin
            if (cmd_push) begin
               if (at_end) begin
                  state_in = F_IDLE;
               end else begin
                  py_in = py_ff + ROW_W'(1);
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the diamond geometry while its rows are issued
   always_ff @(posedge clock) begin
      py_ff    <= py_in;
      up_hi_ff <= up_hi_in;
      dn_lo_ff <= dn_lo_in;
      dn_hi_ff <= dn_hi_in;
      dn_ne_ff <= dn_ne_in;
      if (accept) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         cx_ff  <= cx_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
      end
   end

   a_row_visible: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> ({1'b0, cmd.row} < rows_lim))
      else $error("front issued a row outside the grid");

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd.row_gap <= cmd.half_v))
      else $error("front issued a distance beyond the half-extent");

endmodule

// ===== rtl/core/dsf_queue.sv =====
// ----------------------------------------------------------------------------
// dsf_queue
// Short register queue of row commands between front and back end.
// ----------------------------------------------------------------------------
module dsf_queue import dsf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   output logic    full,
   input  logic    pop,
   output cmd_type dout,
   output logic    valid
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign dout    = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue fill count overran its depth");

endmodule

// ===== rtl/core/dsf_back.sv =====
// ----------------------------------------------------------------------------
// dsf_back
// Works one row command: multiplies the horizontal half-extent by the row
// distance, divides by the vertical half-extent two bits a cycle, clips the
// span to the grid and holds it in the output register.
// ----------------------------------------------------------------------------
module dsf_back import dsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   input  logic [CSR_W-1:0] cols_lim,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [ROW_W-1:0] out_row,
   output logic [COL_W-1:0] out_first,
   output logic [COL_W-1:0] out_final,
   output logic             out_has,
   output logic             out_last
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_MUL  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_CLIP = 2'd3;

   localparam int DIV_STEPS = PROD_W / 2;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam coord_type ZERO = '0;
   localparam coord_type ONE  = coord_type'(1);

   logic [1:0]        state_ff, state_in;
   cmd_type           cmd_ff;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [HALF_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;
   logic              valid_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  first_ff, final_ff;
   logic              has_ff, last_ff;

   logic [HALF_W:0]   trial;
   logic [HALF_W-1:0] off;
   coord_type         cx, off_ext, left, right, cmax, first_c, final_c;
   logic              has, out_free, load;

   assign q_pop    = (state_ff == B_IDLE) && q_valid;
   assign out_free = !valid_ff || rsp_tready;
   assign load     = (state_ff == B_CLIP) && out_free;

   // two restoring division steps per cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, quo_in[PROD_W-1]};
         quo_in = {quo_in[PROD_W-2:0], 1'b0};
         if (trial >= {1'b0, cmd_ff.half_v}) begin
            trial     = trial - {1'b0, cmd_ff.half_v};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[HALF_W-1:0];
      end
   end

   // clip the span to [0, cols_lim)
   always_comb begin
      off     = (cmd_ff.half_v == '0) ? '0 : quo_ff[HALF_W-1:0];
      cx      = {{(COORD_W-8){cmd_ff.center_x[7]}}, cmd_ff.center_x};
      off_ext = {{(COORD_W-HALF_W){1'b0}}, off};
      left    = cx - off_ext;
      right   = cx + off_ext;
      cmax    = coord_type'({{(COORD_W-CSR_W){1'b0}}, cols_lim}) - ONE;
      first_c = (left < ZERO) ? ZERO : left;
      final_c = (right > cmax) ? cmax : right;
      has     = (first_c <= final_c);
   end

   // sequence pop, multiply, divide, clip
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            state_in = B_DIV;
         end
         B_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = B_CLIP;
            end
         end
         B_CLIP: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      case (state_ff)
         B_MUL: begin
            quo_ff  <= cmd_ff.half_h * cmd_ff.row_gap;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         B_DIV: begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
         end
         default: begin
         end
      endcase
      if (load) begin
         row_ff   <= cmd_ff.row;
         first_ff <= has ? first_c[COL_W-1:0] : '0;
         final_ff <= has ? final_c[COL_W-1:0] : '0;
         has_ff   <= has;
         last_ff  <= cmd_ff.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign out_row    = row_ff;
   assign out_first  = first_ff;
   assign out_final  = final_ff;
   assign out_has    = has_ff;
   assign out_last   = last_ff;

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_CLIP) && (cmd_ff.half_v != '0)) |-> (quo_ff <= PROD_W'(cmd_ff.half_h)))
      else $error("edge offset exceeds the horizontal half-extent");

   a_span_in_grid: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && has_ff) |-> ((final_ff < cols_lim) && (first_ff <= final_ff)))
      else $error("span leaves the grid columns");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the diamond scanline span filler.
// ----------------------------------------------------------------------------
// Diamonds go in on the request stream and each span beat that comes back is
// checked against a local row-by-row model of the scan. That model covers the
// top pass, the bottom pass, row skipping and column clipping. The run walks
// through several grid settings, zero-size and oversized ones among them. Both
// streams idle at random. One long response stall fills the block, and sender
// pauses let the block drain completely.
// ----------------------------------------------------------------------------
module testbench;
   import dsf_pkg::*;

   localparam int DRAIN_CYCLES   = 600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int NUM_PHASES     = 8;
   localparam int NUM_DIRECTED   = 22;

   // one expected span beat
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] first_column;
      logic [COL_W-1:0] final_column;
      logic             has_pixels;
      logic             last_span;
   } span_type;

   // Tracks the grid size and the span beats that the accepted diamonds owe.
   class span_scoreboard;
      span_type expected_spans[$];
      int       grid_rows;
      int       grid_cols;
      int       errors;

      function new();
         grid_rows = GRID_ROWS_MAX;
         grid_cols = GRID_COLS_MAX;
         errors    = 0;
      endfunction

      function void set_grid(int rows, int cols);
         grid_rows = rows;
         grid_cols = cols;
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction

      // edge offset at distance row_gap from a vertex; a flat diamond has none
      function int edge_offset(int half_h, int half_v, int row_gap);
         if (half_v == 0) begin
            return 0;
         end
         return (half_h * row_gap) / half_v;
      endfunction

      // queue the clipped span of one row, unless the row is off the grid
      function void push_span(int py, int cx, int off, int rows_lim, int cols_lim);
         span_type s;
         int       lo_col;
         int       hi_col;
         if (py < 0 || py >= rows_lim) begin
            return;
         end
         lo_col = (cx - off < 0) ? 0 : cx - off;
         hi_col = (cx + off > cols_lim - 1) ? cols_lim - 1 : cx + off;
         s.row       = ROW_W'(py);
         s.last_span = 1'b0;
         if (lo_col <= hi_col) begin
            s.first_column = COL_W'(lo_col);
            s.final_column = COL_W'(hi_col);
            s.has_pixels   = 1'b1;
         end else begin
            s.first_column = '0;
            s.final_column = '0;
            s.has_pixels   = 1'b0;
         end
         expected_spans.push_back(s);
      endfunction

      // work out every span of an accepted diamond, in scan order
      function void note_diamond(logic [31:0] beat);
         int       cx;
         int       cy;
         int       half_v;
         int       half_h;
         int       top;
         int       bot;
         int       rows_lim;
         int       cols_lim;
         int       py;
         int       before_count;
         span_type tail;
         cx       = int'($signed(beat[7:0]));
         cy       = int'($signed(beat[15:8]));
         half_v   = int'(beat[23:17]);
         half_h   = int'(beat[31:25]);
         rows_lim = (grid_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : grid_rows;
         cols_lim = (grid_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : grid_cols;
         top      = cy - half_v;
         bot      = cy + half_v;
         before_count = expected_spans.size();
         // top pass down to the centre row, then centre row down to the bottom
         for (py = top; py <= cy; py++) begin
            push_span(py, cx, edge_offset(half_h, half_v, py - top), rows_lim, cols_lim);
         end
         for (py = cy; py <= bot; py++) begin
            push_span(py, cx, edge_offset(half_h, half_v, bot - py), rows_lim, cols_lim);
         end
         // mark the final visible row of this diamond
         if (expected_spans.size() > before_count) begin
            tail = expected_spans.pop_back();
            tail.last_span = 1'b1;
            expected_spans.push_back(tail);
         end
      endfunction

      // compare one span beat against the oldest expectation
      function void check_span(logic [23:0] beat, logic pixels, logic tail);
         span_type want;
         if (expected_spans.size() == 0) begin
            $error("span beat with nothing owed: row %0d", beat[4:0]);
            errors++;
            return;
         end
         want = expected_spans.pop_front();
         if (beat[4:0] !== want.row) begin
            $error("row: expected %0d, actual %0d", want.row, beat[4:0]);
            errors++;
         end
         if (beat[10:5] !== want.first_column) begin
            $error("first_column: expected %0d, actual %0d", want.first_column, beat[10:5]);
            errors++;
         end
         if (beat[16:11] !== want.final_column) begin
            $error("final_column: expected %0d, actual %0d", want.final_column, beat[16:11]);
            errors++;
         end
         if (beat[23:17] !== 7'd0) begin
            $error("tdata padding: expected 0, actual %0h", beat[23:17]);
            errors++;
         end
         if (pixels !== want.has_pixels) begin
            $error("has_pixels: expected %0d, actual %0d", want.has_pixels, pixels);
            errors++;
         end
         if (tail !== want.last_span) begin
            $error("last_span: expected %0d, actual %0d", want.last_span, tail);
            errors++;
         end
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             csr_wr_en  = 1'b0;
   logic [0:0]       csr_index  = CSR_GRID_ROWS;
   logic [CSR_W-1:0] csr_wdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // [7:0] center_x, [15:8] center_y, [23:16] shape_width, [31:24] shape_height
   logic [31:0]      req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // [4:0] row, [10:5] first_column, [16:11] final_column, [23:17] zero
   logic [23:0]      rsp_tdata;
   // [0] has_pixels
   logic [0:0]       rsp_tuser;
   logic             rsp_tlast;

   span_scoreboard sb = new();

   int diamonds_taken = 0;
   int spans_seen     = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   // grid setting of each phase and the random diamonds sent under it
   int phase_rows  [NUM_PHASES] = '{32, 63,  0, 32,  1, 17, 40, 32};
   int phase_cols  [NUM_PHASES] = '{40, 63, 40,  0,  1, 23,  5, 40};
   int phase_items [NUM_PHASES] = '{70, 40, 15, 25, 30, 60, 30, 40};

   // center_x, center_y, shape_width, shape_height
   int directed_set [NUM_DIRECTED][4] = '{
      '{  10,   10,   0,   0}, '{  20,   15,  20,  30}, '{  20,   15,  21,  31},
      '{-128, -128, 255, 255}, '{ 127,  127, 255, 255}, '{   0,    0, 255, 255},
      '{-128,   16, 255, 255}, '{  39,   31,   6,  80}, '{   0,    0,   2,   0},
      '{   5,   -3,  10,  10}, '{   5,   29,  10,  10}, '{  -1,   10,   8,   8},
      '{  40,   10,   8,   8}, '{  20,   16,  64, 254}, '{  20,   32,   2,   2},
      '{  20,   -1,   2,   2}, '{  20,   10,   1, 255}, '{  20,   10, 255,   1},
      '{ 127, -128,   0,   0}, '{-128,  127,   0,   0}, '{  19,   15, 254, 127},
      '{   3,    3,   3,   3}
   };

   diamond_scanline_span_fill DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both streams at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_diamond(req_tdata);
            diamonds_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_span(rsp_tdata, rsp_tuser[0], rsp_tlast);
            spans_seen++;
         end
      end
   end

   // give up when neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: one long hold-off early on, a stretch with no stalls, random
   // stalls elsewhere.
   always @(negedge clock) begin
      if (!hold_done && diamonds_taken >= 40) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (spans_seen >= 1500 && spans_seen < 2500) begin
         rsp_tready = 1'b1;
      end else begin
         rsp_tready = ($urandom_range(99) >= 31);
      end
   end

   // offer one diamond and hold it until the block takes it
   task automatic send_diamond(input logic [31:0] beat);
      @(negedge clock);
      if (!(items_sent >= 150 && items_sent < 210)) begin
         while ($urandom_range(99) < 31) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tdata  = beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every owed span has come back
   task automatic drain_spans();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // write both grid registers; only called with the block idle
   task automatic write_grid(input int rows, input int cols);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_GRID_ROWS;
      csr_wdata = CSR_W'(rows);
      @(negedge clock);
      csr_index = CSR_GRID_COLS;
      csr_wdata = CSR_W'(cols);
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_grid(rows, cols);
   endtask

   initial begin
      int          p;
      int          k;
      int          pick;
      int          cx;
      int          cy;
      int          w;
      int          h;
      logic [31:0] beat;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner cases under the reset grid
      for (k = 0; k < NUM_DIRECTED; k++) begin
         send_diamond({8'(directed_set[k][3]), 8'(directed_set[k][2]),
                       8'(directed_set[k][1]), 8'(directed_set[k][0])});
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         // settle the block, including any row scan that yields no span
         if (p > 0) begin
            drain_spans();
            repeat (DRAIN_CYCLES) @(negedge clock);
            write_grid(phase_rows[p], phase_cols[p]);
         end
         for (k = 0; k < phase_items[p]; k++) begin
            // let the block run dry once in the middle of a phase
            if (p == 5 && k == 30) begin
               drain_spans();
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
               beat = $urandom;
            end else begin
               // mostly diamonds near the grid with moderate extents
               cx = $urandom_range(70) - 15;
               cy = $urandom_range(45) - 7;
               w  = (pick < 25) ? $urandom_range(255) : $urandom_range(70);
               h  = $urandom_range(120);
               beat = {8'(h), 8'(w), 8'(cy), 8'(cx)};
            end
            send_diamond(beat);
         end
      end

      drain_spans();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sb.pending() != 0) begin
         $error("spans still owed at end of run: %0d", sb.pending());
      end
      $display("Covered %0d diamonds and %0d span beats across %0d grid settings,",
               diamonds_taken, spans_seen, NUM_PHASES);
      $display("with empty, saturated and single-cell grids and a long response stall.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== diamond_scanline_span_fill.f =====
rtl/core/dsf_pkg.sv
rtl/core/dsf_front.sv
rtl/core/dsf_queue.sv
rtl/core/dsf_back.sv
rtl/core/diamond_scanline_span_fill.sv
test/testbench.sv
